// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker module of the lottery thread picker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lottery thread picker: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lottery thread picker: next-cycle check failed");

`endif

// ----- sv/ltp_pkg.sv -----
// Package with the field widths, item kinds and controller interface types of the picker.
package ltp_pkg;

    localparam int DEF_NUM_THREADS = 8;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 8;
    localparam int RND_W   = 16;
    localparam int TOTAL_W = 11;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd2;

    typedef struct packed {
        logic wr;
        logic cap;
        logic sum_step;
        logic ptr_clr;
        logic div_step;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic idx_ok;
        logic ptr_last;
        logic div_last;
        logic total_zero;
    } t_status;

endpackage

// ----- sv/ltp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module ltp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/ltp_datapath.sv -----
// Datapath of the picker: ticket store, summing pass, remainder unit and ticket scan.
module ltp_datapath #(
    parameter int NUM_THREADS = ltp_pkg::DEF_NUM_THREADS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ltp_pkg::t_cmd               i_cmd,
    output ltp_pkg::t_status            o_status,
    input  logic [ltp_pkg::KIND_W-1:0]  i_kind,
    input  logic [ltp_pkg::IDX_W-1:0]   i_thread_index,
    input  logic [ltp_pkg::CNT_W-1:0]   i_ticket_count,
    input  logic [ltp_pkg::RND_W-1:0]   i_random_value,
    output logic [ltp_pkg::IDX_W-1:0]   o_chosen_thread,
    output logic                        o_none_left,
    output logic [ltp_pkg::TOTAL_W-1:0] o_ticket_total
);

    import ltp_pkg::*;

    localparam int AW    = $clog2(NUM_THREADS);
    localparam int SUM_W = CNT_W + AW;
    localparam int BIT_W = $clog2(RND_W);
    localparam int XW    = IDX_W + AW;

    logic [NUM_THREADS-1:0] r_valid;
    logic                   r_rd_vbit;
    logic                   r_pend_sum;
    logic                   r_pend_scan;
    logic [AW-1:0]          r_ptr;
    logic [AW-1:0]          r_pend_addr;
    logic [SUM_W-1:0]       r_total;
    logic [SUM_W-1:0]       r_rem;
    logic [RND_W-1:0]       r_dvd;
    logic [BIT_W-1:0]       r_bit;
    logic [SUM_W-1:0]       r_run;
    logic                   r_found;
    logic [AW-1:0]          r_pick;
    logic [IDX_W-1:0]       r_out_thread;
    logic                   r_out_none;
    logic [TOTAL_W-1:0]     r_out_total;

    logic [XW-1:0]          idx_ext;
    logic [CNT_W-1:0]       wr_data;
    logic                   rd_en;
    logic [CNT_W-1:0]       ram_q;
    logic [CNT_W-1:0]       rd_tk;
    logic [SUM_W:0]         trial;
    logic [SUM_W:0]         total_ext;
    logic [SUM_W-1:0]       n_run;
    logic [XW-1:0]          pick_ext;
    logic [SUM_W+TOTAL_W-1:0] total_wide;

    assign idx_ext   = {{AW{1'b0}}, i_thread_index};
    assign wr_data   = (i_kind == KIND_LOAD) ? i_ticket_count : '0;
    assign rd_en     = i_cmd.sum_step | i_cmd.scan_step;
    assign rd_tk     = r_rd_vbit ? ram_q : '0;
    assign trial     = {r_rem, r_dvd[RND_W-1]};
    assign total_ext = {1'b0, r_total};
    assign n_run     = r_run + SUM_W'(rd_tk);
    assign pick_ext  = {{IDX_W{1'b0}}, r_pick};
    assign total_wide = {{TOTAL_W{1'b0}}, r_total};

    ltp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_THREADS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (idx_ext[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pend_sum  <= 1'b0;
            r_pend_scan <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_valid[idx_ext[AW-1:0]] <= 1'b1;
            end
            r_pend_sum  <= i_cmd.sum_step;
            r_pend_scan <= i_cmd.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vbit   <= r_valid[r_ptr];
            r_pend_addr <= r_ptr;
            r_ptr       <= r_ptr + AW'(1);
        end
        if (i_cmd.ptr_clr) begin
            r_ptr <= '0;
        end
        if (r_pend_sum) begin
            r_total <= r_total + SUM_W'(rd_tk);
        end
        if (r_pend_scan) begin
            r_run <= n_run;
            if (!r_found && (n_run > r_rem)) begin
                r_found <= 1'b1;
                r_pick  <= r_pend_addr;
            end
        end
        if (i_cmd.div_step) begin
            if (trial >= total_ext) begin
                r_rem <= SUM_W'(trial - total_ext);
            end else begin
                r_rem <= trial[SUM_W-1:0];
            end
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_bit <= r_bit + BIT_W'(1);
        end
        if (i_cmd.cap) begin
            r_ptr   <= '0;
            r_total <= '0;
            r_rem   <= '0;
            r_dvd   <= i_random_value;
            r_bit   <= '0;
            r_run   <= '0;
            r_found <= 1'b0;
            r_pick  <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_thread <= pick_ext[IDX_W-1:0];
            r_out_none   <= (r_total == '0);
            r_out_total  <= total_wide[TOTAL_W-1:0];
        end
    end

    assign o_status.idx_ok     = (idx_ext < XW'(NUM_THREADS));
    assign o_status.ptr_last   = (r_ptr == AW'(NUM_THREADS - 1));
    assign o_status.div_last   = (r_bit == BIT_W'(RND_W - 1));
    assign o_status.total_zero = (r_total == '0);

    assign o_chosen_thread = r_out_thread;
    assign o_none_left     = r_out_none;
    assign o_ticket_total  = r_out_total;

endmodule

// ----- sv/ltp_ctrl.sv -----
// Controller state machine that sequences loads, retires and draws of the picker.
module ltp_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ltp_pkg::KIND_W-1:0] i_kind,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    input  ltp_pkg::t_status           i_status,
    output ltp_pkg::t_cmd              o_cmd
);

    import ltp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_SUM_END,
        S_DIV,
        S_SCAN,
        S_SCAN_END,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    t_cmd   cmd;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld;
        cmd       = '0;
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_LOAD, KIND_RETIRE: begin
                            cmd.wr = i_status.idx_ok;
                        end
                        KIND_DRAW: begin
                            cmd.cap = 1'b1;
                            n_state = S_SUM;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SUM: begin
                cmd.sum_step = 1'b1;
                if (i_status.ptr_last) begin
                    n_state = S_SUM_END;
                end
            end
            S_SUM_END: begin
                cmd.ptr_clr = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (i_status.total_zero) begin
                    n_state = S_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                    if (i_status.div_last) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_status.ptr_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

endmodule

// ----- sv/lottery_thread_picker.sv -----
// Lottery thread picker: a load or retire transaction updates one thread's tickets and
// leaves the input unstalled. A draw transaction sums the ticket store one entry per cycle,
// reduces the random value modulo the total in a one-bit-per-cycle remainder unit, and
// rescans the store for the first thread whose running sum exceeds the remainder. A draw
// keeps the input stalled until its result is loaded, through the two passes over the single
// read port of the ticket store and the 16 remainder steps (when no tickets are left, the
// remainder steps and the rescan are skipped). The result sits in an output register, so a
// new transaction is taken while the previous result waits.
module lottery_thread_picker #(
    parameter int NUM_THREADS = ltp_pkg::DEF_NUM_THREADS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ltp_pkg::KIND_W-1:0]  i_kind,
    input  logic [ltp_pkg::IDX_W-1:0]   i_thread_index,
    input  logic [ltp_pkg::CNT_W-1:0]   i_ticket_count,
    input  logic [ltp_pkg::RND_W-1:0]   i_random_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ltp_pkg::IDX_W-1:0]   o_chosen_thread,
    output logic                        o_none_left,
    output logic [ltp_pkg::TOTAL_W-1:0] o_ticket_total
);

    import ltp_pkg::*;

    t_cmd    cmd;
    t_status status;

    ltp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ltp_datapath #(
        .NUM_THREADS (NUM_THREADS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_kind          (i_kind),
        .i_thread_index  (i_thread_index),
        .i_ticket_count  (i_ticket_count),
        .i_random_value  (i_random_value),
        .o_chosen_thread (o_chosen_thread),
        .o_none_left     (o_none_left),
        .o_ticket_total  (o_ticket_total)
    );

endmodule

// ----- sv/ltp_checker.sv -----
// Port-level checker of the lottery thread picker and its bind to the top level.
`include "assert_macros.svh"

module ltp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [ltp_pkg::KIND_W-1:0]  i_kind,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [ltp_pkg::IDX_W-1:0]   o_chosen_thread,
    input logic                        o_none_left,
    input logic [ltp_pkg::TOTAL_W-1:0] o_ticket_total
);

    import ltp_pkg::*;

    logic                     in_acc;
    logic                     out_wait;
    logic                     draw_acc;
    logic                     upd_acc;
    logic                     fields_zero;
    logic [IDX_W+TOTAL_W:0]   out_word;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_wait    = o_out_valid && i_out_stall;
    assign draw_acc    = in_acc && (i_kind == KIND_DRAW);
    assign upd_acc     = in_acc && ((i_kind == KIND_LOAD) || (i_kind == KIND_RETIRE));
    assign fields_zero = (o_chosen_thread == '0) && (o_ticket_total == '0);
    assign out_word    = {o_chosen_thread, o_none_left, o_ticket_total};

    `LTP_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, out_wait, o_out_valid)

    `LTP_ASSERT_NEXT(a_out_payload_held, i_clk, i_rst_n, out_wait, $stable(out_word))

    `LTP_ASSERT_NEXT(a_draw_stalls, i_clk, i_rst_n, draw_acc, o_in_stall)

    `LTP_ASSERT_NEXT(a_update_one_cycle, i_clk, i_rst_n, upd_acc, !o_in_stall)

    `LTP_ASSERT_SAME(a_none_left_zero, i_clk, i_rst_n, o_out_valid && o_none_left, fields_zero)

endmodule

bind lottery_thread_picker ltp_checker u_ltp_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the lottery thread picker with a ticket-store scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import ltp_pkg::*;

    localparam int THREADS = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2 * THREADS + 24;
    localparam int ITEM_TARGET = 500;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]   thread;
        logic               none;
        logic [TOTAL_W-1:0] total;
    } t_pick;

    class draw_scoreboard;
        logic [CNT_W-1:0] tickets [THREADS];
        t_pick expected_picks [$];
        int errors;
        int draws_checked;
        int empty_draws;

        function new();
            foreach (tickets[i]) tickets[i] = '0;
            errors = 0;
            draws_checked = 0;
            empty_draws = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_picks.size();
        endfunction

        function void note_transaction(input logic [KIND_W-1:0] kind,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [CNT_W-1:0] cnt,
                                       input logic [RND_W-1:0] rnd);
            int unsigned total;
            int unsigned target;
            int unsigned running;
            bit found;
            t_pick p;
            total = 0;
            running = 0;
            found = 0;
            case (kind)
                KIND_LOAD: begin
                    if (idx < THREADS) tickets[idx] = cnt;
                end
                KIND_RETIRE: begin
                    if (idx < THREADS) tickets[idx] = '0;
                end
                KIND_DRAW: begin
                    foreach (tickets[i]) total += tickets[i];
                    p.thread = '0;
                    p.none = (total == 0);
                    p.total = total[TOTAL_W-1:0];
                    if (total != 0) begin
                        target = rnd % total;
                        for (int i = 0; i < THREADS; i++) begin
                            running += tickets[i];
                            if (!found && running > target) begin
                                p.thread = i[IDX_W-1:0];
                                found = 1;
                            end
                        end
                    end
                    expected_picks.push_back(p);
                end
                default: begin
                end
            endcase
        endfunction

        task check_result(input logic [IDX_W-1:0] thread, input logic none,
                          input logic [TOTAL_W-1:0] total);
            t_pick exp_pick;
            if (expected_picks.size() == 0) begin
                report($sformatf("result thread=%0d none=%0b total=%0d with no draw pending",
                                 thread, none, total));
            end else begin
                exp_pick = expected_picks.pop_front();
                draws_checked++;
                if (exp_pick.none) empty_draws++;
                if (thread !== exp_pick.thread)
                    report($sformatf("chosen_thread got %0d expected %0d",
                                     thread, exp_pick.thread));
                if (none !== exp_pick.none)
                    report($sformatf("none_left got %0b expected %0b", none, exp_pick.none));
                if (total !== exp_pick.total)
                    report($sformatf("ticket_total got %0d expected %0d",
                                     total, exp_pick.total));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [KIND_W-1:0]  i_kind = KIND_LOAD;
    logic [IDX_W-1:0]   i_thread_index = '0;
    logic [CNT_W-1:0]   i_ticket_count = '0;
    logic [RND_W-1:0]   i_random_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [IDX_W-1:0]   o_chosen_thread;
    logic               o_none_left;
    logic [TOTAL_W-1:0] o_ticket_total;

    draw_scoreboard sb = new();
    bit tx_idle_on = 0;
    bit rx_idle_on = 0;
    int out_hold = 0;
    int cycles = 0;
    int items_sent = 0;

    lottery_thread_picker #(.NUM_THREADS(THREADS)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_thread_index(i_thread_index),
        .i_ticket_count(i_ticket_count),
        .i_random_value(i_random_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_chosen_thread(o_chosen_thread),
        .o_none_left(o_none_left),
        .o_ticket_total(o_ticket_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return CNT_W'($urandom_range(1, 3));
            default: return CNT_W'($urandom);
        endcase
    endfunction

    function automatic logic [RND_W-1:0] pick_random();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return RND_W'($urandom);
        endcase
    endfunction

    // Results are checked before the new transaction is noted so the queue stays in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_chosen_thread, o_none_left, o_ticket_total);
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_transaction(i_kind, i_thread_index, i_ticket_count, i_random_value);
    end

    always @(posedge i_clk) begin
        if (out_hold != 0) begin
            out_hold <= out_hold - 1;
            i_out_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            out_hold <= gap_len() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d draws pending", cycles, sb.pending());
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                             input logic [CNT_W-1:0] cnt, input logic [RND_W-1:0] rnd);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 9) >= 6) gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_thread_index <= idx;
        i_ticket_count <= cnt;
        i_random_value <= rnd;
        do @(posedge i_clk); while (o_in_stall);
        if (kind != KIND_UNUSED) items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int t;
        int sel;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty store, ignored kind, boundary remainders and a full store.
        send_item(KIND_DRAW, '0, '0, '0);
        send_item(KIND_DRAW, '1, '1, '1);
        send_item(KIND_UNUSED, '1, '1, '1);
        send_item(KIND_DRAW, '0, '0, 16'h1234);
        send_item(KIND_LOAD, 3'd7, 8'd255, '0);
        send_item(KIND_DRAW, '0, '0, '1);
        send_item(KIND_LOAD, 3'd0, 8'd1, '1);
        send_item(KIND_DRAW, '0, '0, '0);
        send_item(KIND_DRAW, '0, '0, 16'h00FF);
        for (t = 1; t < 7; t++) send_item(KIND_LOAD, t[IDX_W-1:0], 8'd255, RND_W'($urandom));
        send_item(KIND_LOAD, 3'd0, 8'd255, '0);
        send_item(KIND_DRAW, '1, '1, '1);
        send_item(KIND_DRAW, '0, '0, '0);
        send_item(KIND_RETIRE, 3'd7, '1, '1);
        send_item(KIND_LOAD, 3'd3, 8'd0, '0);
        send_item(KIND_DRAW, '0, '0, 16'd2039);
        drain();

        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 3);
            tx_idle_on = sel[0];
            rx_idle_on = sel[1];
            repeat ($urandom_range(1, 6))
                send_item(KIND_LOAD, IDX_W'($urandom), pick_count(), RND_W'($urandom));
            repeat ($urandom_range(1, 8)) begin
                sel = $urandom_range(0, 9);
                if (sel <= 5)
                    send_item(KIND_DRAW, IDX_W'($urandom), CNT_W'($urandom), pick_random());
                else if (sel == 6)
                    send_item(KIND_LOAD, IDX_W'($urandom), pick_count(), RND_W'($urandom));
                else if (sel == 7)
                    send_item(KIND_RETIRE, IDX_W'($urandom), CNT_W'($urandom),
                              RND_W'($urandom));
                else if (sel == 8)
                    send_item(KIND_UNUSED, IDX_W'($urandom), CNT_W'($urandom),
                              RND_W'($urandom));
                else
                    send_item(KIND_DRAW, IDX_W'($urandom), CNT_W'($urandom),
                              $urandom_range(0, 1) ? '1 : '0);
            end
            if ($urandom_range(0, 7) == 0) begin
                for (t = 0; t < THREADS; t++)
                    send_item(KIND_RETIRE, t[IDX_W-1:0], CNT_W'($urandom), RND_W'($urandom));
                send_item(KIND_DRAW, IDX_W'($urandom), CNT_W'($urandom), pick_random());
            end
            if ($urandom_range(0, 4) == 0) drain();
        end

        tx_idle_on = 0;
        rx_idle_on = 0;
        drain();
        $display("Run covered %0d load, retire and draw transactions, with %0d draw results.",
                 items_sent, sb.draws_checked);
        $display("Of those draws %0d found no tickets left; idle gaps were on and off per side.",
                 sb.empty_draws);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
